[rtl/cfr_pkg.sv]
package cfr_pkg;

	localparam int FRAME_BYTES = 512;
	localparam int CHUNK_BYTES = 64;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int FILL_W      = 10;
	localparam int LEN_W       = 7;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

[rtl/cfr_store.sv]
module cfr_store
	import cfr_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/chunk_frame_reassembler.sv]
// Channel  Direction  Beat contents
// s_axis   in         tuser: cmd; tdata: seq_tag, chunk_index, chunk_count,
//                     chunk_length, data_byte, read_address
// m_axis   out        tuser: status; tlast: frame_done; tdata: frame_length,
//                     read_data
//
// One transfer in gives one transfer out, through stage one and the output register.
// A new item is taken every cycle unless input is stalled; the frame store is a
// one-port-write, one-port-read memory with a registered read.
// Reset clears the frame control registers; the store itself is not cleared.
// While the output register is held, one further result waits in stage one,
// and input is stalled only when both are occupied.
module chunk_frame_reassembler
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// seq_tag[7:0], chunk_index[15:8], chunk_count[23:16], chunk_length[30:24],
	// data_byte[38:31], read_address[47:39]
	input  logic [47:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_length[9:0], read_data[17:10], zero[23:18]
	output logic [23:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	typedef struct packed {
		status_t           status;
		logic              done;
		logic [FILL_W-1:0] length;
		logic              is_read;
	} result_t;

	logic [7:0]       in_seq, in_idx, in_cnt, in_data;
	logic [LEN_W-1:0] in_len;
	logic [8:0]       in_raddr;
	cmd_t             cmd;

	assign in_seq   = s_axis_tdata[7:0];
	assign in_idx   = s_axis_tdata[15:8];
	assign in_cnt   = s_axis_tdata[23:16];
	assign in_len   = s_axis_tdata[30:24];
	assign in_data  = s_axis_tdata[38:31];
	assign in_raddr = s_axis_tdata[47:39];
	assign cmd      = cmd_t'(s_axis_tuser);

	logic              assembling_q, assembling_n;
	logic [7:0]        exp_seq_q, exp_seq_n;
	logic [7:0]        exp_cnt_q, exp_cnt_n;
	logic [7:0]        next_idx_q, next_idx_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [LEN_W-1:0]  left_q, left_n;

	status_t status;
	logic    done, hdr_ok, we, re;

	logic    accept, advance;
	logic    valid_s1;
	result_t res_s1;
	logic    out_valid_q;
	result_t out_res_q;
	logic [7:0] out_rdata_q;
	logic [7:0] rdata;

	always_comb begin
		assembling_n = assembling_q;
		exp_seq_n    = exp_seq_q;
		exp_cnt_n    = exp_cnt_q;
		next_idx_n   = next_idx_q;
		fill_n       = fill_q;
		left_n       = left_q;
		status       = ST_IGNORED;
		done         = 1'b0;
		hdr_ok       = 1'b0;
		we           = 1'b0;
		re           = 1'b0;
		case (cmd)
			CMD_HEADER: begin
				if (in_cnt != 8'd0 && in_len <= LEN_W'(CHUNK_BYTES)) begin
					if (in_idx == 8'd0) begin
						assembling_n = 1'b1;
						exp_seq_n    = in_seq;
						exp_cnt_n    = in_cnt;
						next_idx_n   = 8'd0;
						fill_n       = '0;
						left_n       = '0;
						hdr_ok       = 1'b1;
					end else if (!assembling_q) begin
						status = ST_IGNORED;
					end else if (left_q != '0 || in_seq != exp_seq_q ||
							in_idx != next_idx_q || in_cnt != exp_cnt_q) begin
						assembling_n = 1'b0;
						left_n       = '0;
						status       = ST_MISMATCH;
					end else begin
						hdr_ok = 1'b1;
					end
					if (hdr_ok) begin
						if ({1'b0, fill_n} + (FILL_W + 1)'(in_len) >
								(FILL_W + 1)'(FRAME_BYTES)) begin
							assembling_n = 1'b0;
							left_n       = '0;
							status       = ST_OVERFLOW;
						end else begin
							status = ST_OK;
							if (in_len == '0) begin
								next_idx_n = next_idx_n + 8'd1;
								if (next_idx_n >= exp_cnt_n || next_idx_n == 8'd0) begin
									assembling_n = 1'b0;
									done         = 1'b1;
								end
							end else begin
								left_n = in_len;
							end
						end
					end
				end
			end
			CMD_DATA: begin
				if (assembling_q && left_q != '0 && fill_q < FILL_W'(FRAME_BYTES)) begin
					we     = 1'b1;
					status = ST_OK;
					fill_n = fill_q + FILL_W'(1);
					left_n = left_q - LEN_W'(1);
					if (left_n == '0) begin
						next_idx_n = next_idx_q + 8'd1;
						if (next_idx_n >= exp_cnt_q || next_idx_n == 8'd0) begin
							assembling_n = 1'b0;
							done         = 1'b1;
						end
					end
				end
			end
			CMD_READ: begin
				if (FILL_W'(in_raddr) < FILL_W'(FRAME_BYTES)) begin
					re     = 1'b1;
					status = ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	cfr_store u_store (
		.clk   (clk),
		.we    (accept && we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (in_data),
		.re    (accept && re),
		.raddr (in_raddr[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assembling_q <= 1'b0;
			exp_seq_q    <= '0;
			exp_cnt_q    <= '0;
			next_idx_q   <= '0;
			fill_q       <= '0;
			left_q       <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				assembling_q <= assembling_n;
				exp_seq_q    <= exp_seq_n;
				exp_cnt_q    <= exp_cnt_n;
				next_idx_q   <= next_idx_n;
				fill_q       <= fill_n;
				left_q       <= left_n;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= '{status: status, done: done, length: fill_n, is_read: re};
		end
		if (advance && valid_s1) begin
			out_res_q   <= res_s1;
			out_rdata_q <= res_s1.is_read ? rdata : 8'd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_rdata_q, out_res_q.length};
	assign m_axis_tuser  = out_res_q.status;
	assign m_axis_tlast  = out_res_q.done;

endmodule

[rtl/cfr_checker.sv]
module cfr_checker
	import cfr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("Stalled output transfer changed.");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ST_OK)
		else $error("Frame completion reported with a failing status.");

	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[17:10] == 8'd0)
		else $error("Read data is not zero on a rejected item.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:0] <= 10'(FRAME_BYTES))
		else $error("Frame length exceeds the store size.");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input stalled while the output register is empty.");

endmodule

bind chunk_frame_reassembler cfr_checker u_cfr_checker (.*);
